### rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types, codes and defaults for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  // fixed field widths of the request and response channels
  localparam int KEY_W    = 16;
  localparam int TAG_W    = 16;
  localparam int FILL_W   = 7;

  // defaults for the top-level parameters
  localparam int DEF_DEPTH    = 64;
  localparam int DEF_KEY_BITS = 16;
  localparam int DEF_TAG_BITS = 16;

  // operation codes
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  // completion codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DQ_LAST,
    S_DQ_CUR,
    S_DN_L,
    S_DN_R,
    S_DN_SEL,
    S_DN_CMP,
    S_FIN
  } state_t;

  // request payload
  typedef struct packed {
    kind_t              kind;
    logic [KEY_W-1:0]   new_key;
    logic [TAG_W-1:0]   new_tag;
  } req_t;

  // response payload
  typedef struct packed {
    logic [KEY_W-1:0]   min_key;
    logic [TAG_W-1:0]   min_tag;
    status_t            status;
    logic [FILL_W-1:0]  fill;
  } rsp_t;

endpackage

### rtl/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Heap entry store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int DEPTH = 64,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/binary_min_heap_queue_core.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Binary min-heap priority queue with insert and remove-minimum operations.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------
//  req     | in  | req_valid / req_stall | kind, new_key, new_tag (req_t)
//  rsp     | out | rsp_valid / rsp_stall | min_key, min_tag, status, fill
//
//  One operation at a time. Insert time grows with the number of levels
//  climbed and remove time with the levels descended; both are set by the
//  single memory read port and the one key comparator that the sequencer
//  shares. Full inserts and empty removes go straight to S_FIN and touch
//  no entry.
//  Reset (rst, synchronous) empties the heap; the entry store is not cleared.
//  A stalled result waits in the output register; a new request is taken
//  meanwhile and finishes up to the point of reporting.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core
  import bmhq_pkg::*;
#(
  parameter int DEPTH    = DEF_DEPTH,
  parameter int KEY_BITS = DEF_KEY_BITS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = CW + 1;
  localparam int DW = KEY_BITS + TAG_BITS;

  state_t state, state_next;

  logic [CW-1:0]       count, count_next;
  logic [AW-1:0]       pos, pos_next;
  logic [AW-1:0]       pick, pick_next;
  logic [DW-1:0]       cur, cur_next;
  logic [DW-1:0]       child, child_next;
  logic [KEY_BITS-1:0] res_key, res_key_next;
  logic [TAG_BITS-1:0] res_tag, res_tag_next;
  status_t             res_status, res_status_next;

  // memory port signals
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rd_data;

  // shared comparator
  logic [KEY_BITS-1:0] cmp_a, cmp_b;
  logic                gt;

  logic          out_load;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] parent;
  logic [IW-1:0] lc, rc, count_ext;
  logic [KEY_BITS-1:0] cur_key, child_key, rd_key;

  assign cur_key   = cur[DW-1:TAG_BITS];
  assign child_key = child[DW-1:TAG_BITS];
  assign rd_key    = rd_data[DW-1:TAG_BITS];
  assign gt        = cmp_a > cmp_b;

  // heap index arithmetic
  assign count_m1  = count - CW'(1);
  assign parent    = (pos - AW'(1)) >> 1;
  assign lc        = IW'({pos, 1'b1});
  assign rc        = lc + IW'(1);
  assign count_ext = IW'(count);

  assign req_stall = (state != S_IDLE);

  bmhq_ram #(
    .DEPTH (DEPTH),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, memory ports and datapath updates
  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    pick_next       = pick;
    cur_next        = cur;
    child_next      = child;
    res_key_next    = res_key;
    res_tag_next    = res_tag;
    res_status_next = res_status;
    we              = 1'b0;
    waddr           = pos;
    wdata           = cur;
    re              = 1'b0;
    raddr           = '0;
    cmp_a           = cur_key;
    cmp_b           = rd_key;
    out_load        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          res_key_next    = '0;
          res_tag_next    = '0;
          res_status_next = ST_DONE;
          if (req.kind == KIND_INSERT) begin
            if (count >= CW'(DEPTH)) begin
              res_status_next = ST_FULL;
              state_next      = S_FIN;
            end else begin
              cur_next   = {KEY_BITS'(req.new_key), TAG_BITS'(req.new_tag)};
              pos_next   = count[AW-1:0];
              count_next = count + CW'(1);
              state_next = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_FIN;
            end else begin
              // fetch the root
              re         = 1'b1;
              raddr      = '0;
              state_next = S_DQ_LAST;
            end
          end
        end
      end
      // sift up: fetch the parent or settle at the root
      S_UP_RD: begin
        if (pos == '0) begin
          we         = 1'b1;
          state_next = S_FIN;
        end else begin
          re         = 1'b1;
          raddr      = parent;
          state_next = S_UP_CMP;
        end
      end
      // parent not smaller than the new key moves down into the hole
      S_UP_CMP: begin
        cmp_a = cur_key;
        cmp_b = rd_key;
        if (gt) begin
          we         = 1'b1;
          state_next = S_FIN;
        end else begin
          we         = 1'b1;
          wdata      = rd_data;
          pos_next   = parent;
          state_next = S_UP_RD;
        end
      end
      // root arrives; fetch the last entry
      S_DQ_LAST: begin
        res_key_next = rd_key;
        res_tag_next = rd_data[TAG_BITS-1:0];
        re           = 1'b1;
        raddr        = count_m1[AW-1:0];
        count_next   = count_m1;
        state_next   = S_DQ_CUR;
      end
      S_DQ_CUR: begin
        cur_next   = rd_data;
        pos_next   = '0;
        state_next = S_DN_L;
      end
      // sift down: fetch the left child or settle
      S_DN_L: begin
        if (lc >= count_ext) begin
          // nothing to place once the last entry was removed
          we         = (count != '0);
          state_next = S_FIN;
        end else begin
          re         = 1'b1;
          raddr      = lc[AW-1:0];
          pick_next  = lc[AW-1:0];
          state_next = S_DN_R;
        end
      end
      // left child arrives; fetch the right one if present
      S_DN_R: begin
        child_next = rd_data;
        if (rc < count_ext) begin
          re         = 1'b1;
          raddr      = rc[AW-1:0];
          state_next = S_DN_SEL;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      // right child wins only when strictly smaller
      S_DN_SEL: begin
        cmp_a = child_key;
        cmp_b = rd_key;
        if (gt) begin
          child_next = rd_data;
          pick_next  = rc[AW-1:0];
        end
        state_next = S_DN_CMP;
      end
      // child not greater moves up into the hole
      S_DN_CMP: begin
        cmp_a = child_key;
        cmp_b = cur_key;
        if (gt) begin
          we         = 1'b1;
          state_next = S_FIN;
        end else begin
          we         = 1'b1;
          wdata      = child;
          pos_next   = pick;
          state_next = S_DN_L;
        end
      end
      // hand the result to the output register once it is free
      S_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    pick       <= pick_next;
    cur        <= cur_next;
    child      <= child_next;
    res_key    <= res_key_next;
    res_tag    <= res_tag_next;
    res_status <= res_status_next;
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.min_key <= KEY_W'(res_key);
      rsp.min_tag <= TAG_W'(res_tag);
      rsp.status  <= res_status;
      rsp.fill    <= FILL_W'(count);
    end
  end

  // entry count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // every read lies below the entry count
  a_read_held: assert property (@(posedge clk) disable iff (rst)
    re |-> CW'(raddr) < count)
    else $error("read of an entry that is not held");

  // every write lies below the entry count
  a_write_held: assert property (@(posedge clk) disable iff (rst)
    we |-> CW'(waddr) < count)
    else $error("write beyond the held entries");

  // a taken result is not shown again unless a new one is loaded
  a_rsp_once: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && state != S_FIN) |=> !rsp_valid)
    else $error("result repeated after transfer");

  // an empty remove leaves the heap empty
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.kind == KIND_REMOVE && count == '0)
      |=> count == '0)
    else $error("empty remove changed the entry count");

endmodule

### tb/binary_min_heap_queue_core_test.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core_test
// Self-checking bench for the min-heap priority queue core. Every request
// transfer is run through a behavioral heap kept in the bench. The result
// that the heap predicts, or a pinned row's result, is queued, and each
// result transfer is compared with it field by field. A short directed
// table goes first, then random segments that move through fill-heavy
// and drain-heavy mixes and several idle and stall patterns.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core_test;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH     = DEF_DEPTH;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int SEGMENTS       = 10;
  localparam int SEGMENT_ITEMS  = 125;
  localparam int LONG_HOLD      = 400;
  localparam int PRESSURE_ITEMS = 30;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // directed rows carry a typed result alongside the request
  logic pin_now = 1'b0;
  rsp_t pin_rsp = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  int error_count   = 0;
  int insert_count  = 0;
  int remove_count  = 0;
  int full_count    = 0;
  int empty_count   = 0;
  int result_count  = 0;

  // behavioral heap and the results it has predicted
  logic [KEY_W-1:0] slot_key [HEAP_DEPTH];
  logic [TAG_W-1:0] slot_tag [HEAP_DEPTH];
  int               heap_size = 0;
  rsp_t             expected_rsp [$];

  typedef struct {
    req_t op;
    bit   pinned;
    rsp_t want;
  } plan_row_t;

  plan_row_t directed_plan [$];

  binary_min_heap_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  function automatic void exchange_entries(input int a, input int b);
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k = slot_key[a];
    t = slot_tag[a];
    slot_key[a] = slot_key[b];
    slot_tag[a] = slot_tag[b];
    slot_key[b] = k;
    slot_tag[b] = t;
  endfunction

  // one heap operation: equal keys climb on insert and sink on remove
  function automatic rsp_t heap_apply(input req_t op);
    rsp_t res;
    int   pos;
    int   up;
    int   lc;
    int   pick;
    res = '0;
    res.status = ST_DONE;
    if (op.kind == KIND_INSERT) begin
      if (heap_size >= HEAP_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        slot_key[heap_size] = op.new_key;
        slot_tag[heap_size] = op.new_tag;
        heap_size++;
        pos = heap_size - 1;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (slot_key[pos] > slot_key[up]) break;
          exchange_entries(pos, up);
          pos = up;
        end
      end
    end else begin
      if (heap_size == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.min_key = slot_key[0];
        res.min_tag = slot_tag[0];
        exchange_entries(0, heap_size - 1);
        heap_size--;
        pos = 0;
        while (2 * pos + 1 < heap_size) begin
          lc = 2 * pos + 1;
          pick = lc;
          // left child wins a tie
          if (lc + 1 < heap_size && slot_key[lc] > slot_key[lc + 1]) pick = lc + 1;
          if (slot_key[pick] > slot_key[pos]) break;
          exchange_entries(pos, pick);
          pos = pick;
        end
      end
    end
    res.fill = heap_size[FILL_W-1:0];
    return res;
  endfunction

  // request transfer: predict and queue the result
  always @(posedge clk) begin
    rsp_t predicted;
    if (!rst && req_valid && !req_stall) begin
      predicted = heap_apply(req);
      if (pin_now) predicted = pin_rsp;
      if (req.kind == KIND_INSERT) insert_count++;
      else remove_count++;
      if (predicted.status == ST_FULL) full_count++;
      if (predicted.status == ST_EMPTY) empty_count++;
      expected_rsp.push_back(predicted);
    end
  end

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      error_count++;
    end
  endtask

  // result transfer: compare with the oldest prediction
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      result_count++;
      if (expected_rsp.size() == 0) begin
        $display("%0t: result with none expected: key %h tag %h status %0d fill %0d",
                 $time, rsp.min_key, rsp.min_tag, rsp.status, rsp.fill);
        error_count++;
      end else begin
        want = expected_rsp.pop_front();
        check_field("min_key", want.min_key, rsp.min_key);
        check_field("min_tag", want.min_tag, rsp.min_tag);
        check_field("status", 16'(want.status), 16'(rsp.status));
        check_field("fill", 16'(want.fill), 16'(rsp.fill));
      end
    end
  end

  // receiver: random stall, or a long hold counted down here
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("binary_min_heap_queue_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void plan(input kind_t k, input logic [15:0] key,
                               input logic [15:0] tag, input bit pinned,
                               input logic [15:0] wkey, input logic [15:0] wtag,
                               input status_t wst, input logic [6:0] wfill);
    plan_row_t row;
    row.op.kind    = k;
    row.op.new_key = key;
    row.op.new_tag = tag;
    row.pinned     = pinned;
    row.want       = '{min_key: wkey, min_tag: wtag, status: wst, fill: wfill};
    directed_plan.push_back(row);
  endfunction

  function automatic logic [15:0] pick_key();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(7));
      1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t make_op(input int insert_pct);
    req_t op;
    op.kind    = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
    op.new_key = pick_key();
    op.new_tag = 16'($urandom);
    return op;
  endfunction

  // offer one request and hold it until its transfer
  task automatic drive_op(input req_t op, input bit pinned, input rsp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= op;
    pin_now   <= pinned;
    pin_rsp   <= want;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_rsp.size() != 0);
  endtask

  initial begin
    int insert_pct;
    // empty remove, extremes of key and tag, equal keys, back to empty
    plan(KIND_REMOVE, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000, ST_EMPTY, 7'd0);
    plan(KIND_INSERT, 16'hFFFF, 16'h0000, 1, 16'h0000, 16'h0000, ST_DONE, 7'd1);
    plan(KIND_INSERT, 16'h0000, 16'hFFFF, 1, 16'h0000, 16'h0000, ST_DONE, 7'd2);
    plan(KIND_REMOVE, 16'hFFFF, 16'hFFFF, 1, 16'h0000, 16'hFFFF, ST_DONE, 7'd1);
    plan(KIND_INSERT, 16'h8000, 16'hAAAA, 0, '0, '0, ST_DONE, '0);
    plan(KIND_INSERT, 16'h7FFF, 16'h5555, 0, '0, '0, ST_DONE, '0);
    plan(KIND_INSERT, 16'h0005, 16'h0001, 0, '0, '0, ST_DONE, '0);
    plan(KIND_INSERT, 16'h0005, 16'h0002, 0, '0, '0, ST_DONE, '0);
    plan(KIND_INSERT, 16'h0005, 16'h0003, 0, '0, '0, ST_DONE, '0);
    plan(KIND_INSERT, 16'h0005, 16'h0004, 0, '0, '0, ST_DONE, '0);
    plan(KIND_INSERT, 16'h0000, 16'h0000, 0, '0, '0, ST_DONE, '0);
    repeat (8) plan(KIND_REMOVE, 16'h1234, 16'hFEDC, 0, '0, '0, ST_DONE, '0);
    plan(KIND_REMOVE, 16'hFFFF, 16'hFFFF, 1, 16'h0000, 16'h0000, ST_EMPTY, 7'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i])
      drive_op(directed_plan[i].op, directed_plan[i].pinned, directed_plan[i].want);

    // random segments cycle through filling up, draining and a balanced mix
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 46; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 46; end
        default: begin send_idle_pct = 7; stall_pct <= 7; end
      endcase
      case (seg)
        0, 3, 6: insert_pct = 85;
        1, 4, 7: insert_pct = 15;
        default: insert_pct = 55;
      endcase
      // long receiver hold while requests keep coming
      if (seg == 3) begin
        send_idle_pct = 0;
        hold_left <= LONG_HOLD;
        repeat (PRESSURE_ITEMS) drive_op(make_op(100), 1'b0, '0);
      end
      repeat (SEGMENT_ITEMS) drive_op(make_op(insert_pct), 1'b0, '0);
      // sender pauses until every result is back
      if (seg == 5) wait_for_drain();
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d inserts and %0d removes, %0d of them on a full heap",
             insert_count, remove_count, full_count);
    $display("and %0d on an empty one; %0d results compared, %0d field mismatches",
             empty_count, result_count, error_count);
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("binary_min_heap_queue_core: match");
    end else begin
      $display("binary_min_heap_queue_core: mismatch");
    end
    $finish;
  end

endmodule
